// File: design/bppe_pkg.sv
// Package: shared types and constants of the beat phase pulse envelope.
package bppe_pkg;

  localparam int unsigned TempoW = 24;
  localparam int unsigned RateW  = 20;
  localparam int unsigned FrameW = 32;
  localparam int unsigned WinW   = 40;
  localparam int unsigned DvdW   = 40;

  localparam logic [TempoW-1:0] TempoReset = 24'd30720;
  localparam logic [RateW-1:0]  RateReset  = 20'd48000;
  // seconds per minute times the Q8 scale of the tempo
  localparam logic [DvdW-1:0]   BeatScale  = 40'd15360;
  localparam logic [7:0]        LevelMax   = 8'd255;

  // register indexes
  localparam logic [1:0] CfgTempo    = 2'd0;
  localparam logic [1:0] CfgRate     = 2'd1;
  localparam logic [1:0] CfgDownbeat = 2'd2;

  typedef enum logic [2:0] {
    DerIdle = 3'b001,
    DerDivA = 3'b010,
    DerDivB = 3'b100
  } bppe_der_state_e;

  // classified item between front and back
  typedef struct packed {
    logic [FrameW-1:0] since;
    logic              pv;
    logic              ok;
  } bppe_item_t;

  // derived timing handed to front and back
  typedef struct packed {
    logic              busy;
    logic [FrameW-1:0] fpb;
    logic [FrameW-1:0] downbeat;
    logic [WinW-1:0]   window;
    logic [WinW-2:0]   half;
  } bppe_cfg_t;

endpackage

// File: design/bppe_in_if.sv
// Interface: input channel carrying one song frame word.
interface bppe_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_position;
  modport source (output valid, output frame_position, input ready);
  modport sink (input valid, input frame_position, output ready);
endinterface

// File: design/bppe_out_if.sv
// Interface: output channel carrying one beat result word.
interface bppe_out_if;
  logic       valid;
  logic       ready;
  logic       position_valid;
  logic [1:0] beat_in_bar;
  logic       pulse_active;
  logic [7:0] pulse_level;
  logic       tempo_ok;
  modport source (output valid, output position_valid, output beat_in_bar,
                  output pulse_active, output pulse_level, output tempo_ok, input ready);
  modport sink (input valid, input position_valid, input beat_in_bar,
                input pulse_active, input pulse_level, input tempo_ok, output ready);
endinterface

// File: design/bppe_derive.sv
// Module: configuration registers, serial beat length divider and window digit divider.
module bppe_derive #(
  parameter logic [7:0] PulseNum = 8'd1,
  parameter logic [8:0] PulseDen = 9'd4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  output bppe_pkg::bppe_cfg_t cfg_o
);

  localparam int unsigned DvdW     = bppe_pkg::DvdW;
  localparam int unsigned DigN     = DvdW / 8;
  localparam int unsigned DenShift = 25;
  // reciprocal of the window denominator, exact for 16-bit partial dividends
  localparam logic [25:0] DenRecip =
    26'(((64'd1 << DenShift) + 64'(PulseDen) - 64'd1) / 64'(PulseDen));

  logic [bppe_pkg::TempoW-1:0] tempo_q;
  logic [bppe_pkg::RateW-1:0]  rate_q;
  logic [31:0]                 downbeat_q;
  logic                        pend_q;
  bppe_pkg::bppe_der_state_e   state_q;
  logic [DvdW-1:0]             dvd_q;
  logic [bppe_pkg::TempoW-1:0] dvs_q;
  logic [bppe_pkg::TempoW:0]   rem_q;
  logic [5:0]                  cnt_q;
  logic [31:0]                 fpb_q;
  logic [bppe_pkg::WinW-1:0]   window_q;
  logic [bppe_pkg::WinW-2:0]   half_q;

  logic [bppe_pkg::TempoW:0] rs, rem_n;
  logic                      ge;
  logic [DvdW-1:0]           dvd_n, num;
  logic [31:0]               fpb_n;
  logic                      last_it;
  logic [15:0]               dg_p;
  logic [41:0]               dg_prod;
  logic [7:0]                dg_q;
  logic [8:0]                dg_r;
  logic [DvdW-1:0]           dg_dvd;

  // one restoring step per cycle
  always_comb begin
    rs      = {rem_q[bppe_pkg::TempoW-1:0], dvd_q[DvdW-1]};
    ge      = rs >= {1'b0, dvs_q};
    rem_n   = ge ? rs - {1'b0, dvs_q} : rs;
    dvd_n   = {dvd_q[DvdW-2:0], ge};
    last_it = cnt_q == 6'(DvdW - 1);
    num     = DvdW'(rate_q) * bppe_pkg::BeatScale + DvdW'(tempo_q >> 1);
    if (tempo_q == '0 || rate_q == '0 || dvd_n == '0 || dvd_n[DvdW-1:32] != '0) begin
      fpb_n = '0;
    end else begin
      fpb_n = dvd_n[31:0];
    end
  end

  // one byte digit of the window per cycle by reciprocal multiplication
  always_comb begin
    dg_p    = {rem_q[7:0], dvd_q[DvdW-1 -: 8]};
    dg_prod = 42'(dg_p) * 42'(DenRecip);
    dg_q    = dg_prod[DenShift +: 8];
    dg_r    = 9'(dg_p - 16'(dg_q) * 16'(PulseDen));
    dg_dvd  = {dvd_q[DvdW-9:0], dg_q};
  end

  // hold registers, sequence the two divisions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q    <= bppe_pkg::TempoReset;
      rate_q     <= bppe_pkg::RateReset;
      downbeat_q <= '0;
      pend_q     <= 1'b1;
      state_q    <= bppe_pkg::DerIdle;
      dvd_q      <= '0;
      dvs_q      <= '0;
      rem_q      <= '0;
      cnt_q      <= '0;
      fpb_q      <= '0;
      window_q   <= '0;
      half_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bppe_pkg::CfgTempo: begin
            tempo_q <= cfg_data_i[bppe_pkg::TempoW-1:0];
            pend_q  <= 1'b1;
          end
          bppe_pkg::CfgRate: begin
            rate_q <= cfg_data_i[bppe_pkg::RateW-1:0];
            pend_q <= 1'b1;
          end
          bppe_pkg::CfgDownbeat: begin
            downbeat_q <= cfg_data_i;
            pend_q     <= 1'b1;
          end
          default: ;
        endcase
      end
      case (state_q)
        bppe_pkg::DerIdle: begin
          if (pend_q && !cfg_we_i) begin
            pend_q  <= 1'b0;
            dvd_q   <= num;
            dvs_q   <= tempo_q;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= bppe_pkg::DerDivA;
          end
        end
        bppe_pkg::DerDivA: begin
          rem_q <= rem_n;
          dvd_q <= dvd_n;
          cnt_q <= cnt_q + 6'd1;
          if (last_it) begin
            fpb_q   <= fpb_n;
            dvd_q   <= DvdW'(fpb_n) * DvdW'(PulseNum);
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= bppe_pkg::DerDivB;
          end
        end
        bppe_pkg::DerDivB: begin
          rem_q <= (bppe_pkg::TempoW+1)'(dg_r);
          dvd_q <= dg_dvd;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(DigN - 1)) begin
            window_q <= dg_dvd;
            half_q   <= (bppe_pkg::WinW-1)'((dg_dvd - DvdW'(1)) >> 1);
            state_q  <= bppe_pkg::DerIdle;
          end
        end
        default: state_q <= bppe_pkg::DerIdle;
      endcase
    end
  end

  assign cfg_o.busy     = pend_q || (state_q != bppe_pkg::DerIdle);
  assign cfg_o.fpb      = fpb_q;
  assign cfg_o.downbeat = downbeat_q;
  assign cfg_o.window   = window_q;
  assign cfg_o.half     = half_q;

endmodule

// File: design/bppe_front.sv
// Module: front stage that takes frame words and classifies them against the downbeat.
module bppe_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bppe_in_if.sink              in_s,
  input  bppe_pkg::bppe_cfg_t  cfg_i,
  input  logic                 space_i,
  output logic                 push_o,
  output bppe_pkg::bppe_item_t item_o
);

  logic                 valid_q;
  bppe_pkg::bppe_item_t item_q;
  bppe_pkg::bppe_item_t item_d;
  logic                 take;

  assign push_o     = valid_q && space_i;
  assign in_s.ready = !cfg_i.busy && (!valid_q || space_i);
  assign take       = in_s.valid && in_s.ready;
  assign item_o     = item_q;

  // classify the incoming frame
  always_comb begin
    item_d.ok    = cfg_i.fpb != '0;
    item_d.pv    = item_d.ok && (in_s.frame_position >= cfg_i.downbeat);
    item_d.since = item_d.pv ? in_s.frame_position - cfg_i.downbeat : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

// File: design/bppe_queue.sv
// Module: two-word queue between front and back.
module bppe_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bppe_pkg::bppe_item_t item_i,
  output logic                 space_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output bppe_pkg::bppe_item_t item_o
);

  bppe_pkg::bppe_item_t mem_q [2];
  logic                 wr_q, rd_q;
  logic [1:0]           cnt_q;
  logic                 do_pop;

  assign valid_o = cnt_q != 2'd0;
  assign do_pop  = pop_i && valid_o;
  assign space_o = cnt_q != 2'd2;
  assign item_o  = mem_q[rd_q];

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

// File: design/bppe_back.sv
// Module: back pipeline: beat division, window test and envelope division.
module bppe_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bppe_pkg::bppe_cfg_t  cfg_i,
  input  logic                 valid_i,
  input  bppe_pkg::bppe_item_t item_i,
  output logic                 pop_o,
  bppe_out_if.source           out_s
);

  localparam int unsigned DivN = 32;
  localparam int unsigned EnvN = 8;
  localparam int unsigned RemW = 48;

  typedef struct packed {
    logic        valid;
    logic        pv;
    logic        ok;
    logic [31:0] n;
    logic [31:0] r;
    logic [31:0] q;
  } div_st_t;

  typedef struct packed {
    logic            valid;
    logic            pv;
    logic            ok;
    logic            pa;
    logic            full;
    logic [1:0]      beat;
    logic [RemW-1:0] rem;
    logic [7:0]      q;
  } env_st_t;

  div_st_t div_q [DivN];
  env_st_t env_q [EnvN+1];
  logic    en;

  function automatic div_st_t div_step(div_st_t s, logic [31:0] dv);
    logic [32:0] rs;
    logic        ge;
    div_st_t     o;
    rs      = {s.r, s.n[31]};
    ge      = rs >= {1'b0, dv};
    o       = s;
    o.r     = ge ? 32'(rs - {1'b0, dv}) : rs[31:0];
    o.n     = {s.n[30:0], 1'b0};
    o.q     = {s.q[30:0], ge};
    return o;
  endfunction

  function automatic env_st_t env_step(env_st_t s, logic [bppe_pkg::WinW-2:0] h,
                                       int unsigned k);
    logic [RemW-1:0] sh;
    env_st_t         o;
    sh  = RemW'(h) << k;
    o   = s;
    if (s.rem >= sh) begin
      o.rem  = s.rem - sh;
      o.q[k] = 1'b1;
    end
    return o;
  endfunction

  div_st_t                  div_in;
  env_st_t                  env_in;
  logic [bppe_pkg::WinW-1:0] d_w, last, ld;
  logic [31:0]              rise;

  assign en    = !env_q[EnvN].valid || out_s.ready;
  assign pop_o = en;

  // load a queued word or a bubble
  always_comb begin
    div_in       = '0;
    div_in.valid = valid_i;
    div_in.pv    = item_i.pv;
    div_in.ok    = item_i.ok;
    div_in.n     = item_i.since;
  end

  // window test and envelope dividend
  always_comb begin
    d_w         = bppe_pkg::WinW'(div_q[DivN-1].r);
    last        = cfg_i.window - bppe_pkg::WinW'(1);
    ld          = last - d_w;
    rise        = (d_w <= ld) ? div_q[DivN-1].r : ld[31:0];
    env_in      = '0;
    env_in.valid = div_q[DivN-1].valid;
    env_in.pv   = div_q[DivN-1].pv;
    env_in.ok   = div_q[DivN-1].ok;
    env_in.beat = div_q[DivN-1].q[1:0];
    env_in.pa   = div_q[DivN-1].pv && (cfg_i.window != '0) && (d_w < cfg_i.window);
    env_in.full = cfg_i.half == '0;
    env_in.rem  = RemW'(rise) * RemW'(bppe_pkg::LevelMax);
  end

  // advance all stages together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivN; i++) div_q[i].valid <= 1'b0;
      for (int i = 0; i <= EnvN; i++) env_q[i].valid <= 1'b0;
    end else if (en) begin
      div_q[0] <= div_step(div_in, cfg_i.fpb);
      for (int i = 1; i < DivN; i++) div_q[i] <= div_step(div_q[i-1], cfg_i.fpb);
      env_q[0] <= env_in;
      for (int i = 1; i <= EnvN; i++) begin
        env_q[i] <= env_step(env_q[i-1], cfg_i.half, EnvN - i);
      end
    end
  end

  assign out_s.valid          = env_q[EnvN].valid;
  assign out_s.position_valid = env_q[EnvN].pv;
  assign out_s.beat_in_bar    = env_q[EnvN].pv ? env_q[EnvN].beat : 2'd0;
  assign out_s.pulse_active   = env_q[EnvN].pa;
  assign out_s.pulse_level    = !env_q[EnvN].pa ? 8'd0 :
                                env_q[EnvN].full ? bppe_pkg::LevelMax : env_q[EnvN].q;
  assign out_s.tempo_ok       = env_q[EnvN].ok;

endmodule

// File: design/beat_phase_pulse_envelope.sv
// Top level: beat phase pulse envelope built from derive, front, queue and back.
// Path: an accepted frame word passes the front register, the queue and then the back pipeline.
// Throughput: one word per cycle while the derive unit is idle and the output is not stalled; the back
// pipeline has 32 division and 9 envelope stages. After reset or a register write the derive unit runs
// 40 beat length steps and 5 window digit steps; input ready stays low during that time.
// Reset is asynchronous active low and restores tempo 120 BPM, 48 kHz, downbeat 0.
module beat_phase_pulse_envelope #(
  parameter logic [7:0] PULSE_FRAC_NUM = 8'd1,
  parameter logic [8:0] PULSE_FRAC_DEN = 9'd4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  bppe_in_if.sink     in_s,
  bppe_out_if.source  out_s
);

  bppe_pkg::bppe_cfg_t  cfg;
  bppe_pkg::bppe_item_t f_item, q_item;
  logic                 push, space, q_valid, pop;

  bppe_derive #(.PulseNum(PULSE_FRAC_NUM), .PulseDen(PULSE_FRAC_DEN)) u_derive (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  bppe_front u_front (
    .clk_i, .rst_ni, .in_s, .cfg_i(cfg), .space_i(space), .push_o(push), .item_o(f_item)
  );

  bppe_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(f_item), .space_o(space),
    .pop_i(pop), .valid_o(q_valid), .item_o(q_item)
  );

  bppe_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .valid_i(q_valid), .item_i(q_item), .pop_o(pop), .out_s
  );

endmodule
